[rtl/sfnm_pkg.sv]
// Shared constants, types and the legal-character check for the 8.3
// short-name former and matcher. No dependencies.
package sfnm_pkg;

  // Name layout
  localparam int          NAME_BYTES = 11;
  localparam logic [3:0]  BASE_CHARS = 4'd8;
  localparam logic [3:0]  EXT_LEN    = 4'd3;
  localparam logic [3:0]  EXT_START  = 4'd8;

  // Counter limits
  localparam logic [3:0]  CHAR_MAX   = 4'd12;
  localparam logic [3:0]  CHAR_SAT   = 4'd13;

  // Character codes
  localparam logic [7:0]  CH_NUL      = 8'h00;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  CH_DOT      = 8'h2E;
  localparam logic [7:0]  CH_LOWER_A  = 8'h61;
  localparam logic [7:0]  CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0]  CASE_OFFSET = 8'h20;
  localparam logic [7:0]  DEL_MARK    = 8'hE5;
  localparam logic [7:0]  DEL_SUBST   = 8'h05;

  // Formed name handed from the former to the top level
  typedef struct packed {
    logic        valid;
    logic [63:0] base;
    logic [23:0] ext;
  } sfnm_result_t;

  // Legal short-name character, applied after upper-casing
  function automatic logic legal_char(input logic [7:0] c);
    logic ok;
    begin
      case (c) inside
        [8'h41:8'h5A], [8'h30:8'h39],
        8'h20, 8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E,
        8'h60, 8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23,
        8'h26: ok = 1'b1;
        default: ok = 1'b0;
      endcase
      legal_char = ok;
    end
  endfunction

endpackage

[rtl/sfnm_former.sv]
// Name state and 8.3 forming: takes one byte per step and, on the last
// step, presents the formed name and its validity. Uses sfnm_pkg.
module sfnm_former (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            name_byte,
  input  logic                  last_byte,
  output sfnm_pkg::sfnm_result_t result
);

  logic [3:0] char_count_r, char_count_nxt;
  logic [3:0] base_count_r, base_count_nxt;
  logic [3:0] ext_count_r, ext_count_nxt;
  logic       dot_seen_r, dot_seen_nxt;
  logic       name_bad_r, name_bad_nxt;
  logic       ended_r, ended_nxt;
  logic [7:0] formed_r   [sfnm_pkg::NAME_BYTES];
  logic [7:0] formed_nxt [sfnm_pkg::NAME_BYTES];
  logic [7:0] ch;
  logic       valid_c;
  logic [7:0] byte0;

  // Per-byte update of the name state
  always_comb begin
    char_count_nxt = char_count_r;
    base_count_nxt = base_count_r;
    ext_count_nxt  = ext_count_r;
    dot_seen_nxt   = dot_seen_r;
    name_bad_nxt   = name_bad_r;
    ended_nxt      = ended_r;
    formed_nxt     = formed_r;
    // ASCII upper-casing
    if (name_byte >= sfnm_pkg::CH_LOWER_A && name_byte <= sfnm_pkg::CH_LOWER_Z) begin
      ch = name_byte - sfnm_pkg::CASE_OFFSET;
    end else begin
      ch = name_byte;
    end
    if (!ended_r) begin
      if (name_byte == sfnm_pkg::CH_NUL) begin
        ended_nxt = 1'b1;
      end else begin
        if (char_count_r < sfnm_pkg::CHAR_SAT) begin
          char_count_nxt = char_count_r + 4'd1;
        end
        if (name_byte == sfnm_pkg::CH_DOT) begin
          // second dot spoils the name
          if (dot_seen_r) begin
            name_bad_nxt = 1'b1;
          end else begin
            dot_seen_nxt = 1'b1;
          end
        end else begin
          if (!sfnm_pkg::legal_char(ch)) begin
            name_bad_nxt = 1'b1;
          end
          if (!dot_seen_r) begin
            if (base_count_r < sfnm_pkg::BASE_CHARS) begin
              formed_nxt[{1'b0, base_count_r[2:0]}] = ch;
            end
            if (base_count_r < sfnm_pkg::BASE_CHARS + 4'd1) begin
              base_count_nxt = base_count_r + 4'd1;
            end
          end else begin
            if (ext_count_r < sfnm_pkg::EXT_LEN) begin
              formed_nxt[sfnm_pkg::EXT_START + {2'b00, ext_count_r[1:0]}] = ch;
            end
            if (ext_count_r < sfnm_pkg::EXT_LEN + 4'd1) begin
              ext_count_nxt = ext_count_r + 4'd1;
            end
          end
        end
      end
    end
  end

  // Validity and packing of the formed name
  always_comb begin
    valid_c = !name_bad_nxt &&
              char_count_nxt >= 4'd1 && char_count_nxt <= sfnm_pkg::CHAR_MAX &&
              base_count_nxt >= 4'd1 && base_count_nxt <= sfnm_pkg::BASE_CHARS &&
              ext_count_nxt <= sfnm_pkg::EXT_LEN;
    // deleted-entry marker is stored as its substitute
    byte0 = (formed_nxt[0] == sfnm_pkg::DEL_MARK) ? sfnm_pkg::DEL_SUBST : formed_nxt[0];
    result.valid = valid_c;
    result.base  = '0;
    result.ext   = '0;
    if (valid_c) begin
      result.base[7:0] = byte0;
      for (int i = 1; i < 8; i++) begin
        result.base[8*i +: 8] = formed_nxt[i];
      end
      for (int j = 0; j < 3; j++) begin
        result.ext[8*j +: 8] = formed_nxt[8 + j];
      end
    end
  end

  // State registers; a last step returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      char_count_r <= '0;
      base_count_r <= '0;
      ext_count_r  <= '0;
      dot_seen_r   <= 1'b0;
      name_bad_r   <= 1'b0;
      ended_r      <= 1'b0;
      for (int k = 0; k < sfnm_pkg::NAME_BYTES; k++) begin
        formed_r[k] <= sfnm_pkg::CH_SPACE;
      end
    end else if (step) begin
      char_count_r <= char_count_nxt;
      base_count_r <= base_count_nxt;
      ext_count_r  <= ext_count_nxt;
      dot_seen_r   <= dot_seen_nxt;
      name_bad_r   <= name_bad_nxt;
      ended_r      <= ended_nxt;
      formed_r     <= formed_nxt;
    end
  end

endmodule

[rtl/short_name_format_and_match.sv]
// The result is registered: a name's last byte passes the input register, then the
// result register, which presents the formed name and the match flags.
// Throughput: one name byte per cycle; only a last byte waits, while
// an untaken result holds the result register. Synchronous active-low reset
// clears all control state and the name state (formed name back to all spaces).
// Top level of the 8.3 short-name former and matcher; uses sfnm_pkg and sfnm_former.
module short_name_format_and_match (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_name_byte,
  input  logic        in_last_byte,
  input  logic [63:0] in_disk_base,
  input  logic [23:0] in_disk_ext,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_name_valid,
  output logic        out_name_matches,
  output logic [63:0] out_short_base,
  output logic [23:0] out_short_ext
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [63:0] s1_base_r;
  logic [23:0] s1_ext_r;
  logic        s1_adv;
  logic        step;
  logic        in_take;
  logic        out_load;
  logic        out_valid_r;
  logic        out_name_valid_r;
  logic        out_name_matches_r;
  logic [63:0] out_short_base_r;
  logic [23:0] out_short_ext_r;
  sfnm_pkg::sfnm_result_t res;

  // Flow control: only a last byte needs room in the result register
  assign s1_adv   = !s1_valid_r || !s1_last_r || !out_valid_r || !out_stall;
  assign step     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign out_load = step && s1_last_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_name_byte;
      s1_last_r <= in_last_byte;
      s1_base_r <= in_disk_base;
      s1_ext_r  <= in_disk_ext;
    end
  end

  sfnm_former u_former (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .name_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .result    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_name_valid_r   <= res.valid;
      out_name_matches_r <= res.valid && (res.base == s1_base_r) && (res.ext == s1_ext_r);
      out_short_base_r   <= res.base;
      out_short_ext_r    <= res.ext;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_name_valid   = out_name_valid_r;
  assign out_name_matches = out_name_matches_r;
  assign out_short_base   = out_short_base_r;
  assign out_short_ext    = out_short_ext_r;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench for short_name_format_and_match: streams file names byte by byte and
// checks each formed 8.3 short name, valid flag and disk match against a predictor.
// Depends on sfnm_pkg and the short_name_format_and_match RTL.
module testbench;

  // Predictor state for the name being taken
  typedef struct packed {
    logic [3:0]       n_chars;
    logic             dotted;
    logic [3:0]       n_base;
    logic [3:0]       n_ext;
    logic             bad;
    logic             done;
    logic [10:0][7:0] formed;
  } name_state_t;

  // One expected result transaction
  typedef struct packed {
    logic        ok;
    logic        hit;
    logic [63:0] base;
    logic [23:0] ext;
  } short_name_t;

  typedef enum int {DISK_SAME, DISK_FLIP, DISK_RANDOM} disk_mode_t;

  localparam name_state_t NAME_IDLE = '{n_chars: 4'd0, dotted: 1'b0, n_base: 4'd0,
                                        n_ext: 4'd0, bad: 1'b0, done: 1'b0,
                                        formed: {11{sfnm_pkg::CH_SPACE}}};

  // Punctuation allowed in a short name; index 0 is the space
  localparam logic [16:0][7:0] NAME_SPECIALS = {
    8'h26, 8'h23, 8'h5E, 8'h7D, 8'h7B, 8'h29, 8'h28, 8'h21, 8'h60,
    8'h7E, 8'h40, 8'h5F, 8'h2D, 8'h27, 8'h25, 8'h24, 8'h20};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_name_byte;
  logic        in_last_byte;
  logic [63:0] in_disk_base;
  logic [23:0] in_disk_ext;
  logic        out_valid;
  logic        out_stall;
  logic        out_name_valid;
  logic        out_name_matches;
  logic [63:0] out_short_base;
  logic [23:0] out_short_ext;

  name_state_t name_in_progress;
  short_name_t expected_names[$];
  logic [7:0]  name_bytes[$];
  bit          steady_flow = 1'b0;
  int          errors = 0;
  int          bytes_used = 0;
  int          names_checked = 0;
  int          names_ok = 0;
  int          names_hit = 0;

  short_name_format_and_match i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_name_byte     (in_name_byte),
    .in_last_byte     (in_last_byte),
    .in_disk_base     (in_disk_base),
    .in_disk_ext      (in_disk_ext),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_name_valid   (out_name_valid),
    .out_name_matches (out_name_matches),
    .out_short_base   (out_short_base),
    .out_short_ext    (out_short_ext)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic is_name_char(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39)) return 1'b1;
    for (int k = 0; k < 17; k++)
      if (c == NAME_SPECIALS[k]) return 1'b1;
    return 1'b0;
  endfunction

  // Fold one accepted name byte into the running state
  function automatic name_state_t fold_name_byte(input name_state_t s, input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (s.done) return s;
    if (c == sfnm_pkg::CH_NUL) begin
      s.done = 1'b1;
      return s;
    end
    if (s.n_chars < sfnm_pkg::CHAR_SAT) s.n_chars = s.n_chars + 4'd1;
    if (c == sfnm_pkg::CH_DOT) begin
      if (s.dotted) s.bad = 1'b1;
      else s.dotted = 1'b1;
      return s;
    end
    if (c >= sfnm_pkg::CH_LOWER_A && c <= sfnm_pkg::CH_LOWER_Z) begin
      c = c - sfnm_pkg::CASE_OFFSET;
    end
    if (!is_name_char(c)) s.bad = 1'b1;
    // Overlong parts saturate one past the limit and store nothing more
    if (!s.dotted) begin
      if (s.n_base < sfnm_pkg::BASE_CHARS) s.formed[s.n_base] = c;
      if (s.n_base <= sfnm_pkg::BASE_CHARS) s.n_base = s.n_base + 4'd1;
    end else begin
      if (s.n_ext < sfnm_pkg::EXT_LEN) s.formed[sfnm_pkg::EXT_START + s.n_ext] = c;
      if (s.n_ext <= sfnm_pkg::EXT_LEN) s.n_ext = s.n_ext + 4'd1;
    end
    return s;
  endfunction

  // Result for a name closed by the last flag
  function automatic short_name_t finish_name(input name_state_t s, input logic [63:0] db,
                                              input logic [23:0] de);
    short_name_t      r;
    logic [10:0][7:0] f;
    r.ok = !s.bad && s.n_chars >= 4'd1 && s.n_chars <= sfnm_pkg::CHAR_MAX &&
           s.n_base >= 4'd1 && s.n_base <= sfnm_pkg::BASE_CHARS &&
           s.n_ext <= sfnm_pkg::EXT_LEN;
    f = s.formed;
    if (f[0] == sfnm_pkg::DEL_MARK) f[0] = sfnm_pkg::DEL_SUBST;
    r.base = r.ok ? 64'(f[7:0]) : '0;
    r.ext  = r.ok ? 24'(f[10:8]) : '0;
    r.hit  = r.ok && r.base == db && r.ext == de;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Mostly no gap, some short, a few long; none during steady stretches
  function automatic int idle_cycles();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one name byte; predict once the transaction is taken
  task automatic send_name_item(input logic [7:0] b, input logic last,
                                input logic [63:0] db, input logic [23:0] de);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_name_byte <= b;
    in_last_byte <= last;
    in_disk_base <= db;
    in_disk_ext  <= de;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_used++;
    name_in_progress = fold_name_byte(name_in_progress, b);
    if (last) begin
      expected_names.push_back(finish_name(name_in_progress, db, de));
      name_in_progress = NAME_IDLE;
    end
  endtask

  // Send the queued name; the disk name rides on the last byte only
  task automatic send_pending(input disk_mode_t mode);
    name_state_t  s;
    short_name_t  f;
    logic [63:0]  db;
    logic [23:0]  de;
    logic [87:0]  both;
    int           last_idx;
    s = NAME_IDLE;
    foreach (name_bytes[i]) s = fold_name_byte(s, name_bytes[i]);
    f = finish_name(s, '0, '0);
    case (mode)
      DISK_SAME: begin
        db = f.base;
        de = f.ext;
      end
      DISK_FLIP: begin
        both = {f.ext, f.base} ^ (88'd1 << $urandom_range(0, 87));
        db = both[63:0];
        de = both[87:64];
      end
      default: begin
        db = {$urandom(), $urandom()};
        de = 24'($urandom());
      end
    endcase
    last_idx = name_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      if (i == last_idx) send_name_item(name_bytes[i], 1'b1, db, de);
      else send_name_item(name_bytes[i], 1'b0, {$urandom(), $urandom()}, 24'($urandom()));
    end
    name_bytes.delete();
  endtask

  task automatic add_text(input string t);
    for (int k = 0; k < t.len(); k++) name_bytes.push_back(t[k]);
  endtask

  function automatic logic [7:0] pick_legal();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 6) return 8'($urandom_range(sfnm_pkg::CH_LOWER_A, sfnm_pkg::CH_LOWER_Z));
    if (r < 8) return 8'($urandom_range(8'h30, 8'h39));
    return NAME_SPECIALS[$urandom_range(0, 16)];
  endfunction

  task automatic push_legal(input int n);
    repeat (n) name_bytes.push_back(pick_legal());
  endtask

  // Well-formed base, optional extension, optional terminator with trailing junk
  task automatic build_good_name();
    push_legal($urandom_range(1, 8));
    if ($urandom_range(0, 2) != 0) begin
      name_bytes.push_back(sfnm_pkg::CH_DOT);
      push_legal($urandom_range(0, 3));
    end
    if ($urandom_range(0, 1) == 1) begin
      name_bytes.push_back(sfnm_pkg::CH_NUL);
      repeat ($urandom_range(0, 3)) name_bytes.push_back(8'($urandom()));
    end
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_names.size() != 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_name_forms();
    add_text("README.TXT");
    name_bytes.push_back(sfnm_pkg::CH_NUL);
    send_pending(DISK_SAME);
    // lower case folded, no terminator
    add_text("a.b");
    send_pending(DISK_SAME);
    // trailing dot leaves an empty extension
    add_text("q.");
    send_pending(DISK_SAME);
    // empty name
    name_bytes.push_back(sfnm_pkg::CH_NUL);
    send_pending(DISK_SAME);
    // bytes after the terminator are ignored, the last one too
    add_text("Q");
    name_bytes.push_back(sfnm_pkg::CH_NUL);
    add_text("?!");
    send_pending(DISK_SAME);
    // every punctuation mark, first name at the full twelve characters
    for (int k = 0; k < 8; k++) name_bytes.push_back(NAME_SPECIALS[k]);
    name_bytes.push_back(sfnm_pkg::CH_DOT);
    for (int k = 8; k < 11; k++) name_bytes.push_back(NAME_SPECIALS[k]);
    send_pending(DISK_SAME);
    for (int k = 11; k < 17; k++) name_bytes.push_back(NAME_SPECIALS[k]);
    send_pending(DISK_FLIP);
  endtask

  task automatic test_name_limits();
    add_text("12345678");
    send_pending(DISK_FLIP);
    add_text("ABCDEFGHI");
    send_pending(DISK_SAME);
    add_text(".TXT");
    send_pending(DISK_SAME);
    add_text("A.BCDE");
    send_pending(DISK_SAME);
    add_text("A.B.C");
    send_pending(DISK_SAME);
    // counters run into saturation
    add_text("ABCDEFGHIJ.KLMNO");
    send_pending(DISK_RANDOM);
  endtask

  task automatic test_bad_chars();
    add_text("A*");
    send_pending(DISK_SAME);
    name_bytes.push_back(8'h7F);
    send_pending(DISK_SAME);
    // deleted-entry mark in front; formed byte 0 would be substituted
    name_bytes.push_back(sfnm_pkg::DEL_MARK);
    add_text("A");
    send_pending(DISK_SAME);
    add_text("B");
    name_bytes.push_back(8'hFF);
    send_pending(DISK_SAME);
    add_text("z+");
    send_pending(DISK_SAME);
  endtask

  task automatic test_random_names(input int n_items);
    int         stop_at;
    int         kind;
    disk_mode_t mode;
    stop_at = bytes_used + n_items;
    while (bytes_used < stop_at) begin
      kind = $urandom_range(0, 99);
      mode = disk_mode_t'($urandom_range(0, 2));
      if (kind < 55) begin
        build_good_name();
      end else if (kind < 75) begin
        // near misses on the length and dot rules
        case ($urandom_range(0, 3))
          0: push_legal($urandom_range(9, 11));
          1: begin
            name_bytes.push_back(sfnm_pkg::CH_DOT);
            push_legal($urandom_range(0, 3));
          end
          2: begin
            push_legal($urandom_range(1, 8));
            name_bytes.push_back(sfnm_pkg::CH_DOT);
            push_legal($urandom_range(4, 5));
          end
          default: begin
            push_legal($urandom_range(1, 3));
            name_bytes.push_back(sfnm_pkg::CH_DOT);
            push_legal($urandom_range(0, 2));
            name_bytes.push_back(sfnm_pkg::CH_DOT);
            push_legal($urandom_range(0, 2));
          end
        endcase
        if ($urandom_range(0, 1) == 1) name_bytes.push_back(sfnm_pkg::CH_NUL);
      end else if (kind < 88) begin
        build_good_name();
        name_bytes[$urandom_range(0, name_bytes.size() - 1)] = 8'($urandom_range(1, 255));
      end else begin
        repeat ($urandom_range(1, 14)) name_bytes.push_back(8'($urandom()));
      end
      send_pending(mode);
    end
  endtask

  task automatic test_steady_stream(input int n_items);
    steady_flow = 1'b1;
    test_random_names(n_items);
    steady_flow = 1'b0;
  endtask

  task automatic test_pause_for_results();
    repeat (20) begin
      build_good_name();
      send_pending(DISK_SAME);
      wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_name_byte     = '0;
    in_last_byte     = 1'b0;
    in_disk_base     = '0;
    in_disk_ext      = '0;
    name_in_progress = NAME_IDLE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_name_forms();
    test_name_limits();
    test_bad_chars();
    test_random_names(800);
    test_steady_stream(300);
    test_pause_for_results();
    test_random_names(600);

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d names from %0d name bytes: %0d legal, %0d equal to the disk entry.",
             names_checked, bytes_used, names_ok, names_hit);
    $display("Sender gaps and result stalls were random, with gap-free and drained stretches.");
    if (errors == 0 && expected_names.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side stall pattern
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest expected name
  always @(posedge clk) begin
    short_name_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_names.size() == 0) begin
        $error("result transaction with no name pending");
        errors++;
      end else begin
        want = expected_names.pop_front();
        names_checked++;
        if (want.ok) names_ok++;
        if (want.hit) names_hit++;
        if (out_name_valid !== want.ok) begin
          $error("name_valid: expected %0b, got %0b", want.ok, out_name_valid);
          errors++;
        end
        if (out_name_matches !== want.hit) begin
          $error("name_matches: expected %0b, got %0b", want.hit, out_name_matches);
          errors++;
        end
        if (out_short_base !== want.base) begin
          $error("short_base: expected %h, got %h", want.base, out_short_base);
          errors++;
        end
        if (out_short_ext !== want.ext) begin
          $error("short_ext: expected %h, got %h", want.ext, out_short_ext);
          errors++;
        end
      end
    end
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/sfnm_pkg.sv
rtl/sfnm_former.sv
rtl/short_name_format_and_match.sv
sim/testbench.sv
